>>> rtl/tile_grid_ray_traversal_macros.svh
// assertion macros used by the tile grid ray traversal controller
`ifndef TILE_GRID_RAY_TRAVERSAL_MACROS_SVH
`define TILE_GRID_RAY_TRAVERSAL_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TGRT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tgrt assertion failed");
// next-cycle implication
`define TGRT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tgrt assertion failed");
`else
`define TGRT_ASSERT_IMP(label, clk, rst, ante, cons)
`define TGRT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/tgrt_pkg.sv
// shared types, constants and codes of the tile grid ray traversal block
package tgrt_pkg;
  localparam int DEF_MAX_GRID_COLUMNS = 128;
  localparam int DEF_MAX_GRID_ROWS    = 128;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_W    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_H    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_H    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DESTROYED = 3'd4;

  localparam int TILE_PX_W  = 7;
  localparam int GRID_W     = 8;
  localparam int COORD_W    = 11;
  localparam int POS_W      = 23;
  localparam int FRAC_W     = 8;
  localparam int HIT_TILE_W = 7;
  // magnitude bits of the integer pixel part handed to the divider
  localparam int DIV_W      = POS_W - FRAC_W - 1;
  // tile size in fixed point pixels
  localparam int PIX_W      = TILE_PX_W + FRAC_W;
  // signed tile coordinate width, holds start tile plus window offsets
  localparam int CW         = 18;

  localparam logic [TILE_PX_W-1:0] RST_TILE_PX    = 7'd16;
  localparam logic [GRID_W-1:0]    RST_GRID_TILES = 8'd128;
  localparam logic [GRID_W-1:0]    RST_DESTROYED  = 8'd0;

  typedef enum logic [1:0] {
    DIV_ORG_X,
    DIV_ORG_Y,
    DIV_DIR_X,
    DIV_DIR_Y
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WR_RD,
    ST_WR_WR,
    ST_DIV_START,
    ST_DIV_RUN,
    ST_SETUP,
    ST_STEP_RD,
    ST_STEP_EV,
    ST_HIT_V,
    ST_HIT_SQ,
    ST_HIT_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic     clr_en;
    logic     load;
    logic     wr_rd;
    logic     wr_wr;
    logic     res_clear;
    logic     div_start;
    logic     div_step;
    logic     div_store;
    div_sel_t div_sel;
    logic     setup;
    logic     step_rd;
    logic     step_en;
    logic     hit_store;
    logic     v_en;
    logic     sq_en;
    logic     cmp_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_ray;
    logic dir_zero;
    logic cull;
    logic div_done;
    logic in_bounds;
    logic solid;
  } sts_t;
endpackage

>>> rtl/tgrt_req_if.sv
// request channel: valid, ready and the request item fields
interface tgrt_req_if
  import tgrt_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic signed [COORD_W-1:0] tile_x;
  logic signed [COORD_W-1:0] tile_y;
  logic                      tile_solid;
  logic signed [POS_W-1:0]   origin_x;
  logic signed [POS_W-1:0]   origin_y;
  logic signed [POS_W-1:0]   dir_x;
  logic signed [POS_W-1:0]   dir_y;
  logic                      cull_mode;

  modport source (output valid, req_type, tile_x, tile_y, tile_solid, origin_x, origin_y,
                  dir_x, dir_y, cull_mode, input ready);
  modport sink (input valid, req_type, tile_x, tile_y, tile_solid, origin_x, origin_y,
                dir_x, dir_y, cull_mode, output ready);
endinterface

>>> rtl/tgrt_res_if.sv
// result channel: valid, ready and the result item fields
interface tgrt_res_if
  import tgrt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [HIT_TILE_W-1:0] hit_tile_x;
  logic [HIT_TILE_W-1:0] hit_tile_y;
  logic                  found_solid;

  modport source (output valid, hit, hit_tile_x, hit_tile_y, found_solid, input ready);
  modport sink (input valid, hit, hit_tile_x, hit_tile_y, found_solid, output ready);
endinterface

>>> rtl/tgrt_ram.sv
// generic single write port ram with registered read
module tgrt_ram #(
  parameter int Width = 1,
  parameter int Depth = 2
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                      wdata,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                      rdata
);
  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/tgrt_dp.sv
// datapath: config registers, tile map, divider, walk registers and range check
module tgrt_dp
  import tgrt_pkg::*;
#(
  parameter int MAX_GRID_COLUMNS = DEF_MAX_GRID_COLUMNS,
  parameter int MAX_GRID_ROWS    = DEF_MAX_GRID_ROWS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic                      req_type,
  input  logic signed [COORD_W-1:0] tile_x,
  input  logic signed [COORD_W-1:0] tile_y,
  input  logic                      tile_solid,
  input  logic signed [POS_W-1:0]   origin_x,
  input  logic signed [POS_W-1:0]   origin_y,
  input  logic signed [POS_W-1:0]   dir_x,
  input  logic signed [POS_W-1:0]   dir_y,
  input  logic                      cull_mode,
  output logic                      hit,
  output logic [HIT_TILE_W-1:0]     hit_tile_x,
  output logic [HIT_TILE_W-1:0]     hit_tile_y,
  output logic                      found_solid
);
  localparam int AW     = MAX_GRID_COLUMNS > 1 ? $clog2(MAX_GRID_COLUMNS) : 1;
  localparam int RB     = MAX_GRID_ROWS > 1 ? $clog2(MAX_GRID_ROWS) : 1;
  localparam int MaxDim = MAX_GRID_COLUMNS > MAX_GRID_ROWS ? MAX_GRID_COLUMNS : MAX_GRID_ROWS;
  localparam int IXB    = $clog2(MaxDim + 1);
  localparam int NW     = PIX_W + $clog2(MaxDim + 2);
  localparam int MW     = NW + POS_W;
  localparam int VW     = ((IXB + PIX_W > POS_W) ? IXB + PIX_W : POS_W) + 2;
  localparam int SW     = 2 * VW + 1;
  localparam int DCW    = $clog2(DIV_W + 1);
  localparam logic signed [CW-1:0] ZERO = '0;
  localparam logic signed [CW-1:0] ONE  = CW'(1);
  localparam logic signed [CW-1:0] TWO  = CW'(2);

  // configuration registers
  logic [TILE_PX_W-1:0] tile_width_px, tile_height_px;
  logic [GRID_W-1:0]    grid_width_tiles, grid_height_tiles, destroyed_below_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width_px          <= RST_TILE_PX;
      tile_height_px         <= RST_TILE_PX;
      grid_width_tiles       <= RST_GRID_TILES;
      grid_height_tiles      <= RST_GRID_TILES;
      destroyed_below_column <= RST_DESTROYED;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILE_W:    tile_width_px          <= cfg_wdata[TILE_PX_W-1:0];
        CFG_TILE_H:    tile_height_px         <= cfg_wdata[TILE_PX_W-1:0];
        CFG_GRID_W:    grid_width_tiles       <= cfg_wdata;
        CFG_GRID_H:    grid_height_tiles      <= cfg_wdata;
        CFG_DESTROYED: destroyed_below_column <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // effective tile size and grid extent
  logic [TILE_PX_W-1:0]   tw, th;
  logic [PIX_W-1:0]       w_fx, h_fx;
  logic signed [CW-1:0]   cols_used, rows_used, dbc_s;

  assign tw = (tile_width_px == '0) ? TILE_PX_W'(1) : tile_width_px;
  assign th = (tile_height_px == '0) ? TILE_PX_W'(1) : tile_height_px;
  assign w_fx = {tw, FRAC_W'(0)};
  assign h_fx = {th, FRAC_W'(0)};
  assign cols_used = (CW'(grid_width_tiles) > CW'(MAX_GRID_COLUMNS)) ?
                     CW'(MAX_GRID_COLUMNS) : CW'(grid_width_tiles);
  assign rows_used = (CW'(grid_height_tiles) > CW'(MAX_GRID_ROWS)) ?
                     CW'(MAX_GRID_ROWS) : CW'(grid_height_tiles);
  assign dbc_s = signed'(CW'(destroyed_below_column));

  // request capture
  logic                      req_type_q, tile_solid_q, cull_q;
  logic signed [COORD_W-1:0] tile_x_q, tile_y_q;
  logic signed [POS_W-1:0]   ox, oy, dx, dy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_q   <= req_type;
      tile_x_q     <= tile_x;
      tile_y_q     <= tile_y;
      tile_solid_q <= tile_solid;
      ox           <= origin_x;
      oy           <= origin_y;
      dx           <= dir_x;
      dy           <= dir_y;
      cull_q       <= cull_mode;
    end
  end

  logic dx_zero, dy_zero, dx_pos, dy_pos;
  assign dx_zero = (dx == '0);
  assign dy_zero = (dy == '0);
  assign dx_pos  = !dx[POS_W-1] && !dx_zero;
  assign dy_pos  = !dy[POS_W-1] && !dy_zero;

  // walk registers
  logic signed [CW-1:0] ix, iy, qdx, qdy;
  logic signed [CW-1:0] min_x, max_x, min_y, max_y;
  logic [TILE_PX_W-1:0] px_rem, py_rem;
  logic [NW-1:0]        nx, ny;
  logic [POS_W-1:0]     adx, ady;
  logic [MW-1:0]        px_prod, py_prod;
  logic                 in_bounds;

  // tile map, one word per column address holding a bit for each row
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr, clr_addr;
  logic [MAX_GRID_ROWS-1:0] ram_wdata, ram_rdata;
  logic              wr_in_bounds;
  logic signed [CW-1:0] wx, wy;

  assign wx = CW'(tile_x_q);
  assign wy = CW'(tile_y_q);
  assign wr_in_bounds = (wx >= ZERO) && (wy >= ZERO) && (wx < cols_used) && (wy < rows_used);

  always_comb begin
    ram_wdata = ram_rdata;
    ram_wdata[tile_y_q[RB-1:0]] = tile_solid_q;
    if (cmd.clr_en) begin
      ram_wdata = '0;
    end
  end

  assign ram_we    = cmd.clr_en || (cmd.wr_wr && wr_in_bounds);
  assign ram_waddr = cmd.clr_en ? clr_addr : tile_x_q[AW-1:0];
  assign ram_raddr = cmd.step_rd ? ix[AW-1:0] : tile_x_q[AW-1:0];

  tgrt_ram #(
    .Width (MAX_GRID_ROWS),
    .Depth (MAX_GRID_COLUMNS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clearing sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // serial floor divider of the integer pixel part by the tile size
  logic signed [POS_W-1:0]  div_src;
  logic [DIV_W:0]           div_a;
  logic [DIV_W-1:0]         div_quo;
  logic [TILE_PX_W-1:0]     div_rem, div_den, div_r;
  logic [DCW-1:0]           div_cnt;
  logic                     div_neg;
  logic [TILE_PX_W:0]       div_t;
  logic                     div_ge;
  logic [DIV_W:0]           div_qu;
  logic signed [CW-1:0]     div_q;

  always_comb begin
    case (cmd.div_sel)
      DIV_ORG_X: div_src = ox;
      DIV_ORG_Y: div_src = oy;
      DIV_DIR_X: div_src = dx;
      DIV_DIR_Y: div_src = dy;
      default:   div_src = ox;
    endcase
  end

  assign div_a  = div_src[POS_W-1:FRAC_W];
  assign div_t  = {div_rem, div_quo[DIV_W-1]};
  assign div_ge = (div_t >= {1'b0, div_den});
  assign div_qu = div_neg ? ~{1'b0, div_quo} : {1'b0, div_quo};
  assign div_q  = CW'(signed'(div_qu));
  assign div_r  = div_neg ? TILE_PX_W'(div_den - TILE_PX_W'(1) - div_rem) : div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= DCW'(DIV_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - DCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_neg <= div_a[DIV_W];
      div_quo <= div_a[DIV_W] ? ~div_a[DIV_W-1:0] : div_a[DIV_W-1:0];
      div_rem <= '0;
      div_den <= (cmd.div_sel == DIV_ORG_X || cmd.div_sel == DIV_DIR_X) ? tw : th;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? TILE_PX_W'(div_t - {1'b0, div_den}) : div_t[TILE_PX_W-1:0];
      div_quo <= {div_quo[DIV_W-2:0], div_ge};
    end
  end

  // window bounds from the start tile and direction quotients
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y, ax, bx, ay, by;
  assign lo_x = dx[POS_W-1] ? qdx : ZERO;
  assign hi_x = dx_pos ? qdx : ZERO;
  assign lo_y = dy[POS_W-1] ? qdy : ZERO;
  assign hi_y = dy_pos ? qdy : ZERO;
  assign ax = ix + lo_x - ONE;
  assign bx = ix + hi_x + TWO;
  assign ay = iy + lo_y - ONE;
  assign by = iy + hi_y + TWO;

  assign in_bounds = (ix >= min_x) && (ix < max_x) && (iy >= min_y) && (iy < max_y);

  // boundary choice from the registered cross products
  logic go_x;
  assign go_x = dy_zero || (!dx_zero && (px_prod < py_prod));

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_ORG_X: begin
          ix     <= div_q;
          px_rem <= div_r;
        end
        DIV_ORG_Y: begin
          iy     <= div_q;
          py_rem <= div_r;
        end
        DIV_DIR_X: qdx <= div_q;
        DIV_DIR_Y: qdy <= div_q;
        default: ;
      endcase
    end else if (cmd.setup) begin
      nx    <= dx_pos ? NW'(w_fx - {px_rem, ox[FRAC_W-1:0]}) : NW'({px_rem, ox[FRAC_W-1:0]});
      ny    <= dy_pos ? NW'(h_fx - {py_rem, oy[FRAC_W-1:0]}) : NW'({py_rem, oy[FRAC_W-1:0]});
      adx   <= dx[POS_W-1] ? POS_W'(-dx) : POS_W'(dx);
      ady   <= dy[POS_W-1] ? POS_W'(-dy) : POS_W'(dy);
      min_x <= (cull_q && ax > ZERO) ? ax : ZERO;
      max_x <= (cull_q && bx < cols_used) ? bx : cols_used;
      min_y <= (cull_q && ay > ZERO) ? ay : ZERO;
      max_y <= (cull_q && by < rows_used) ? by : rows_used;
    end else if (cmd.step_en) begin
      if (go_x) begin
        ix <= dx_pos ? ix + ONE : ix - ONE;
        nx <= nx + NW'(w_fx);
      end else begin
        iy <= dy_pos ? iy + ONE : iy - ONE;
        ny <= ny + NW'(h_fx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_rd) begin
      px_prod <= nx * ady;
      py_prod <= ny * adx;
    end
  end

  // range check of a culled hit: squared distance to tile center
  logic [IXB+TILE_PX_W-1:0]   ix_tw, iy_th;
  logic [IXB+PIX_W-1:0]       cx, cy;
  logic signed [VW-1:0]       vx, vy;
  logic [2*VW-1:0]            sqx, sqy;
  logic [2*POS_W-1:0]         ddx, ddy;
  logic [SW-1:0]              dv, dd;

  assign cx = {ix_tw, FRAC_W'(0)} + (IXB+PIX_W)'({tw, (FRAC_W-1)'(0)});
  assign cy = {iy_th, FRAC_W'(0)} + (IXB+PIX_W)'({th, (FRAC_W-1)'(0)});
  assign ix_tw = ix[IXB-1:0] * tw;
  assign iy_th = iy[IXB-1:0] * th;
  assign dv = SW'(sqx) + SW'(sqy);
  assign dd = SW'(ddx) + SW'(ddy);

  always_ff @(posedge clk) begin
    if (cmd.v_en) begin
      vx <= VW'(ox) - VW'({1'b0, cx});
      vy <= VW'(oy) - VW'({1'b0, cy});
    end
    if (cmd.sq_en) begin
      sqx <= vx * vx;
      sqy <= vy * vy;
      ddx <= adx * adx;
      ddy <= ady * ady;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_clear) begin
      hit         <= 1'b0;
      hit_tile_x  <= '0;
      hit_tile_y  <= '0;
      found_solid <= 1'b0;
    end else if (cmd.hit_store) begin
      hit         <= 1'b1;
      hit_tile_x  <= ix[HIT_TILE_W-1:0];
      hit_tile_y  <= iy[HIT_TILE_W-1:0];
      found_solid <= 1'b1;
    end else if (cmd.cmp_en) begin
      if (dv > dd) begin
        hit <= 1'b0;
      end
    end
  end

  // status to the controller
  assign sts.clr_last  = (clr_addr == AW'(MAX_GRID_COLUMNS - 1));
  assign sts.is_ray    = req_type_q;
  assign sts.dir_zero  = dx_zero && dy_zero;
  assign sts.cull      = cull_q;
  assign sts.div_done  = (div_cnt == '0);
  assign sts.in_bounds = in_bounds;
  assign sts.solid     = ram_rdata[iy[RB-1:0]] && (ix >= dbc_s);
endmodule

>>> rtl/tgrt_ctrl.sv
// controller: sequences clearing, tile writes, the divider and the tile walk
module tgrt_ctrl
  import tgrt_pkg::*;
`include "tile_grid_ray_traversal_macros.svh"
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t   state, state_next;
  div_sel_t div_sel, div_sel_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      div_sel <= DIV_ORG_X;
    end else begin
      state   <= state_next;
      div_sel <= div_sel_next;
    end
  end

  // next state
  always_comb begin
    state_next   = state;
    div_sel_next = div_sel;
    case (state)
      ST_CLEAR:  if (sts.clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (!sts.is_ray) begin
          state_next = ST_WR_RD;
        end else if (sts.dir_zero) begin
          state_next = ST_DONE;
        end else begin
          state_next   = ST_DIV_START;
          div_sel_next = DIV_ORG_X;
        end
      end
      ST_WR_RD:     state_next = ST_WR_WR;
      ST_WR_WR:     state_next = ST_DONE;
      ST_DIV_START: state_next = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (sts.div_done) begin
          if (div_sel == DIV_DIR_Y) begin
            state_next = ST_SETUP;
          end else begin
            state_next   = ST_DIV_START;
            div_sel_next = div_sel_t'(div_sel + 2'd1);
          end
        end
      end
      ST_SETUP:   state_next = ST_STEP_RD;
      ST_STEP_RD: state_next = sts.in_bounds ? ST_STEP_EV : ST_DONE;
      ST_STEP_EV: begin
        if (sts.solid) begin
          state_next = sts.cull ? ST_HIT_V : ST_DONE;
        end else begin
          state_next = ST_STEP_RD;
        end
      end
      ST_HIT_V:   state_next = ST_HIT_SQ;
      ST_HIT_SQ:  state_next = ST_HIT_CMP;
      ST_HIT_CMP: state_next = ST_DONE;
      ST_DONE:    if (out_ready) state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd         = '0;
    cmd.div_sel = div_sel;
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE:    cmd.res_clear = sts.is_ray && sts.dir_zero;
      ST_WR_RD:     cmd.wr_rd = 1'b1;
      ST_WR_WR: begin
        cmd.wr_wr     = 1'b1;
        cmd.res_clear = 1'b1;
      end
      ST_DIV_START: cmd.div_start = 1'b1;
      ST_DIV_RUN: begin
        cmd.div_step  = !sts.div_done;
        cmd.div_store = sts.div_done;
      end
      ST_SETUP: cmd.setup = 1'b1;
      ST_STEP_RD: begin
        cmd.step_rd   = sts.in_bounds;
        cmd.res_clear = !sts.in_bounds;
      end
      ST_STEP_EV: begin
        cmd.hit_store = sts.solid;
        cmd.step_en   = !sts.solid;
      end
      ST_HIT_V:   cmd.v_en = 1'b1;
      ST_HIT_SQ:  cmd.sq_en = 1'b1;
      ST_HIT_CMP: cmd.cmp_en = 1'b1;
      ST_DONE:    out_valid = 1'b1;
      default: ;
    endcase
  end

  `TGRT_ASSERT_IMP(a_ready_not_busy, clk, rst, in_ready, !out_valid)
  `TGRT_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  `TGRT_ASSERT_NXT(a_div_to_setup, clk, rst, state == ST_DIV_RUN && sts.div_done && div_sel == DIV_DIR_Y, state == ST_SETUP)
  `TGRT_ASSERT_IMP(a_read_in_bounds, clk, rst, cmd.step_rd, sts.in_bounds)
endmodule

>>> rtl/tile_grid_ray_traversal.sv
// Tile map write: after accept the controller passes ST_DECODE, ST_WR_RD (map word read) and
// ST_WR_WR (word write), then offers the result in ST_DONE. Ray cast: setup by four serial
// 14-step divisions, then per tile visited ST_STEP_RD (map word read, cross products) and ST_STEP_EV,
// plus ST_HIT_V, ST_HIT_SQ and ST_HIT_CMP to range check a culled hit. A new item is accepted only
// after the last result is taken. Synchronous reset; afterwards the map is swept clear at one column
// a cycle over all MAX_GRID_COLUMNS columns, during which no item is accepted but config writes are.
module tile_grid_ray_traversal
  import tgrt_pkg::*;
#(
  parameter int MAX_GRID_COLUMNS = DEF_MAX_GRID_COLUMNS,
  parameter int MAX_GRID_ROWS    = DEF_MAX_GRID_ROWS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  tgrt_req_if.sink              req,
  tgrt_res_if.source            res
);
  cmd_t cmd;
  sts_t sts;

  // sequencing
  tgrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic, map and result register
  tgrt_dp #(
    .MAX_GRID_COLUMNS (MAX_GRID_COLUMNS),
    .MAX_GRID_ROWS    (MAX_GRID_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req.req_type),
    .tile_x      (req.tile_x),
    .tile_y      (req.tile_y),
    .tile_solid  (req.tile_solid),
    .origin_x    (req.origin_x),
    .origin_y    (req.origin_y),
    .dir_x       (req.dir_x),
    .dir_y       (req.dir_y),
    .cull_mode   (req.cull_mode),
    .hit         (res.hit),
    .hit_tile_x  (res.hit_tile_x),
    .hit_tile_y  (res.hit_tile_y),
    .found_solid (res.found_solid)
  );
endmodule

>>> verif/tb.sv
// testbench of the tile grid ray traversal block: own map model, random rays and writes
module tb
  import tgrt_pkg::*;
;
  typedef struct packed {
    logic                      req_type;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
    logic                      solid;
    logic signed [POS_W-1:0]   ox;
    logic signed [POS_W-1:0]   oy;
    logic signed [POS_W-1:0]   dx;
    logic signed [POS_W-1:0]   dy;
    logic                      cull;
  } tile_req_t;

  typedef struct packed {
    logic                  hit;
    logic [HIT_TILE_W-1:0] hx;
    logic [HIT_TILE_W-1:0] hy;
    logic                  found;
  } tile_res_t;

  localparam int COLS = DEF_MAX_GRID_COLUMNS;
  localparam int ROWS = DEF_MAX_GRID_ROWS;
  localparam int REQ_BITS = $bits(tile_req_t);
  localparam longint CYCLE_LIMIT = 5000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tgrt_req_if req_ch ();
  tgrt_res_if res_ch ();

  tile_grid_ray_traversal dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch.sink),
    .res       (res_ch.source)
  );

  // model state of the map and registers
  bit        solid_map [COLS*ROWS];
  longint    tile_w_px, tile_h_px, grid_cols, grid_rows, destroyed_col;

  tile_req_t pending_reqs [$];
  tile_res_t expected_results [$];
  tile_req_t cur_req;
  bit        req_taken;
  int        req_gap, res_gap;
  bit        no_idle;
  bit        hold_off, hold_trigger;
  longint    n_issued, n_accepted, cycles;
  int        errors;

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint cols_in_use();
    return grid_cols > COLS ? COLS : grid_cols;
  endfunction

  function automatic longint rows_in_use();
    return grid_rows > ROWS ? ROWS : grid_rows;
  endfunction

  function automatic bit tile_is_solid(input longint x, input longint y);
    if (x < 0 || y < 0 || x >= cols_in_use() || y >= rows_in_use()) return 1'b0;
    if (x < destroyed_col) return 1'b0;
    return solid_map[x*ROWS + y];
  endfunction

  // map update for writes, grid walk for rays
  function automatic tile_res_t trace_tile_hit(input tile_req_t it);
    tile_res_t r;
    longint x, y, ox, oy, drx, dry, tw, th, w, h, ix, iy, px, py, adx, ady, nx, ny;
    longint min_x, max_x, min_y, max_y, a, vx, vy;
    bit     in_range;
    r = '0;
    if (!it.req_type) begin
      x = it.tx;
      y = it.ty;
      if (x >= 0 && y >= 0 && x < cols_in_use() && y < rows_in_use())
        solid_map[x*ROWS + y] = it.solid;
      return r;
    end
    ox = it.ox; oy = it.oy; drx = it.dx; dry = it.dy;
    if (drx == 0 && dry == 0) return r;
    tw = tile_w_px ? tile_w_px : 1;
    th = tile_h_px ? tile_h_px : 1;
    w = tw * 256;
    h = th * 256;
    ix = floor_div(ox, w);
    iy = floor_div(oy, h);
    px = ox - ix * w;
    py = oy - iy * h;
    adx = drx < 0 ? -drx : drx;
    ady = dry < 0 ? -dry : dry;
    nx = drx > 0 ? w - px : px;
    ny = dry > 0 ? h - py : py;
    min_x = 0; max_x = cols_in_use(); min_y = 0; max_y = rows_in_use();
    // cull window around the start tile covering the direction
    if (it.cull) begin
      a = ix + floor_div(drx < 0 ? drx : 0, w) - 1; if (a > min_x) min_x = a;
      a = ix + floor_div(drx > 0 ? drx : 0, w) + 2; if (a < max_x) max_x = a;
      a = iy + floor_div(dry < 0 ? dry : 0, h) - 1; if (a > min_y) min_y = a;
      a = iy + floor_div(dry > 0 ? dry : 0, h) + 2; if (a < max_y) max_y = a;
    end
    while (ix >= min_x && ix < max_x && iy >= min_y && iy < max_y) begin
      if (tile_is_solid(ix, iy)) begin
        in_range = 1'b1;
        if (it.cull) begin
          vx = ox - (ix * w + tw * 128);
          vy = oy - (iy * h + th * 128);
          if (vx*vx + vy*vy > drx*drx + dry*dry) in_range = 1'b0;
        end
        r.hit   = in_range;
        r.hx    = ix[HIT_TILE_W-1:0];
        r.hy    = iy[HIT_TILE_W-1:0];
        r.found = 1'b1;
        return r;
      end
      // cross the nearer boundary, row boundary on a tie
      if (dry == 0 || (drx != 0 && nx * ady < ny * adx)) begin
        ix += drx > 0 ? 1 : -1;
        nx += w;
      end else begin
        iy += dry > 0 ? 1 : -1;
        ny += h;
      end
    end
    return r;
  endfunction

  function automatic tile_req_t mk_write(input int x, input int y, input bit s);
    tile_req_t it;
    it = '0;
    it.tx = COORD_W'(x);
    it.ty = COORD_W'(y);
    it.solid = s;
    return it;
  endfunction

  function automatic tile_req_t mk_ray(input int ox, input int oy, input int dx, input int dy,
                                       input bit c);
    tile_req_t it;
    it = '0;
    it.req_type = 1'b1;
    it.ox = POS_W'(ox); it.oy = POS_W'(oy); it.dx = POS_W'(dx); it.dy = POS_W'(dy);
    it.cull = c;
    return it;
  endfunction

  // append one item to the pending queue
  task automatic add_req(input tile_req_t it);
    pending_reqs = {pending_reqs, it};
  endtask

  function automatic int rand_signed(input int bits);
    int v;
    v = int'($urandom & ((1 << bits) - 1));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // tile writes that populate the map, rays from in and just around the grid, some raw noise
  function automatic tile_req_t random_item();
    tile_req_t it;
    longint tw, th, ext_x, ext_y;
    int     sel;
    it = REQ_BITS'({$urandom, $urandom, $urandom, $urandom});
    sel = $urandom_range(0, 99);
    tw = tile_w_px ? tile_w_px : 1;
    th = tile_h_px ? tile_h_px : 1;
    if (sel < 45) begin
      it.req_type = 1'b0;
      if ($urandom_range(0, 19) != 0) begin
        it.tx = COORD_W'($urandom_range(0, int'(cols_in_use() + 1)));
        it.ty = COORD_W'($urandom_range(0, int'(rows_in_use() + 1)));
      end
      it.solid = ($urandom_range(0, 99) < 35);
    end else if (sel < 88) begin
      it.req_type = 1'b1;
      ext_x = (cols_in_use() + 2) * tw * 256;
      ext_y = (rows_in_use() + 2) * th * 256;
      if (ext_x > 4194303) ext_x = 4194303;
      if (ext_y > 4194303) ext_y = 4194303;
      it.ox = POS_W'(longint'($urandom_range(0, int'(ext_x))) - tw * 256);
      it.oy = POS_W'(longint'($urandom_range(0, int'(ext_y))) - th * 256);
      it.dx = POS_W'(rand_signed($urandom_range(0, 22)));
      it.dy = POS_W'(rand_signed($urandom_range(0, 22)));
      case ($urandom_range(0, 9))
        0: it.dx = '0;
        1: it.dy = '0;
        2: it.dy = it.dx;
        default: ;
      endcase
    end else begin
      it.req_type = 1'b1;
    end
    return it;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      CFG_TILE_W:    tile_w_px     = longint'(value & 'h7F);
      CFG_TILE_H:    tile_h_px     = longint'(value & 'h7F);
      CFG_GRID_W:    grid_cols     = longint'(value & 'hFF);
      CFG_GRID_H:    grid_rows     = longint'(value & 'hFF);
      CFG_DESTROYED: destroyed_col = longint'(value & 'hFF);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int tw, input int th, input int gw, input int gh, input int dc);
    write_reg(CFG_TILE_W, tw);
    write_reg(CFG_TILE_H, th);
    write_reg(CFG_GRID_W, gw);
    write_reg(CFG_GRID_H, gh);
    write_reg(CFG_DESTROYED, dc);
  endtask

  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && n_issued == n_accepted && expected_results.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic int gap_len();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // request driver
  always @(negedge clk) begin
    if (!rst && (!req_ch.valid || req_taken)) begin
      req_taken = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        n_issued++;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= cur_req.req_type;
        req_ch.tile_x     <= cur_req.tx;
        req_ch.tile_y     <= cur_req.ty;
        req_ch.tile_solid <= cur_req.solid;
        req_ch.origin_x   <= cur_req.ox;
        req_ch.origin_y   <= cur_req.oy;
        req_ch.dir_x      <= cur_req.dx;
        req_ch.dir_y      <= cur_req.dy;
        req_ch.cull_mode  <= cur_req.cull;
        req_gap = gap_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result ready with random stalls and the long hold-off
  always @(negedge clk) begin
    if (hold_off) begin
      res_ch.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      res_gap = gap_len();
    end
  end

  // hold-off counted here while the sender keeps offering items
  initial begin
    hold_off = 1'b0;
    wait (hold_trigger);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor: predict on accepted requests, compare accepted results
  always @(posedge clk) begin
    tile_res_t got, want;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        expected_results = {expected_results, trace_tile_hit(cur_req)};
        n_accepted++;
        req_taken = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        got = {res_ch.hit, res_ch.hit_tile_x, res_ch.hit_tile_y, res_ch.found_solid};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item %h", $time, got);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
            errors++;
          end
          if (got.hx !== want.hx) begin
            $display("%0t: hit_tile_x expected %0d actual %0d", $time, want.hx, got.hx);
            errors++;
          end
          if (got.hy !== want.hy) begin
            $display("%0t: hit_tile_y expected %0d actual %0d", $time, want.hy, got.hy);
            errors++;
          end
          if (got.found !== want.found) begin
            $display("%0t: found_solid expected %0d actual %0d", $time, want.found, got.found);
            errors++;
          end
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // phases of register settings and stimulus
  initial begin
    req_ch.valid = 1'b0; req_ch.req_type = 1'b0; req_ch.tile_x = '0; req_ch.tile_y = '0;
    req_ch.tile_solid = 1'b0; req_ch.origin_x = '0; req_ch.origin_y = '0;
    req_ch.dir_x = '0; req_ch.dir_y = '0; req_ch.cull_mode = 1'b0;
    res_ch.ready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    req_taken = 1'b0; req_gap = 0; res_gap = 0; no_idle = 1'b0; hold_trigger = 1'b0;
    n_issued = 0; n_accepted = 0; cycles = 0; errors = 0;
    tile_w_px = 16; tile_h_px = 16; grid_cols = 128; grid_rows = 128; destroyed_col = 0;
    foreach (solid_map[i]) solid_map[i] = 1'b0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed items at reset settings, tiles of 4096 in fixed point
    add_req(mk_write(-1024, -1024, 1'b1));
    add_req(mk_write(1023, 1023, 1'b1));
    add_req(mk_write(128, 5, 1'b1));
    add_req(mk_write(5, 128, 1'b1));
    add_req(mk_write(-1, -1, 1'b1));
    add_req(mk_write(0, 0, 1'b1));
    add_req(mk_write(127, 127, 1'b1));
    add_req(mk_write(10, 2, 1'b1));
    add_req(mk_write(2, 6, 1'b1));
    add_req(mk_ray(100, 100, 0, 0, 1'b0));
    add_req(mk_ray(10240, 10240, 256, 0, 1'b0));
    add_req(mk_ray(10240, 10240, 256, 0, 1'b1));
    add_req(mk_ray(34816, 10240, 4196, 0, 1'b1));
    add_req(mk_ray(34816, 10240, 9000, 0, 1'b1));
    add_req(mk_ray(51200, 10240, -300, 0, 1'b0));
    add_req(mk_ray(10240, 10240, 0, 1000, 1'b0));
    add_req(mk_ray(10240, 10240, 1, 1, 1'b0));
    add_req(mk_ray(-4194304, -4194304, 4194303, 4194303, 1'b0));
    add_req(mk_ray(4194303, 4194303, -4194304, -4194304, 1'b1));
    add_req(mk_ray(520191, 520191, 4194303, 4194303, 1'b0));
    add_req(mk_write(0, 0, 1'b0));
    add_req(mk_ray(2048, 2048, -100, -100, 1'b0));
    repeat (220) add_req(random_item());
    wait_drained();

    for (int phase = 1; phase <= 5; phase++) begin
      case (phase)
        1: set_regs(1, 1, 16, 16, 0);
        2: set_regs(64, 64, 128, 128, 4);
        3: set_regs(0, 255, 255, 255, 255);
        4: set_regs(7, 3, 0, 0, 0);
        default: set_regs(16, 16, 40, 24, 10);
      endcase
      no_idle = (phase == 2);
      if (phase == 1) hold_trigger = 1'b1;
      repeat (245) add_req(random_item());
      wait_drained();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/tgrt_pkg.sv
rtl/tgrt_req_if.sv
rtl/tgrt_res_if.sv
rtl/tgrt_ram.sv
rtl/tgrt_dp.sv
rtl/tgrt_ctrl.sv
rtl/tile_grid_ray_traversal.sv
verif/tb.sv
